[design/nns_pkg.sv]
package nns_pkg;

  // default store sizes
  localparam int unsigned DEF_MAX_POINTS  = 256;
  localparam int unsigned DEF_MAX_DIMS    = 8;
  localparam int unsigned DEF_MAX_TARGETS = 4;

  // at most this many results per query
  localparam int unsigned RESULT_LIMIT = 4;

  // distance output width and its saturation value
  localparam int unsigned DIST_W   = 35;
  localparam logic [63:0] DIST_MAX = (64'd1 << DIST_W) - 64'd1;

  // command codes of an input beat
  localparam logic [1:0] FUNC_FEATURE = 2'd0;
  localparam logic [1:0] FUNC_TARGET  = 2'd1;
  localparam logic [1:0] FUNC_QUERY   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_METRIC_MODE  = 2'd0;
  localparam logic [1:0] CFG_POINT_COUNT  = 2'd1;
  localparam logic [1:0] CFG_DIM_COUNT    = 2'd2;
  localparam logic [1:0] CFG_TARGET_COUNT = 2'd3;

  // depth of the search command queue
  localparam int unsigned CMD_DEPTH = 2;

  // search command, counts already clamped to their legal ranges
  typedef struct packed {
    logic       mode;
    logic [8:0] pc;
    logic [3:0] dc;
    logic [2:0] tc;
  } cmd_t;

  // a count of zero acts as one, above the maximum acts as the maximum
  function automatic logic [31:0] clamp_count(logic [31:0] v, logic [31:0] hi);
    logic [31:0] r;
    r = v;
    if (v < 32'd1) begin
      r = 32'd1;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

[design/nns_ram.sv]
module nns_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/nns_front.sv]
module nns_front #(
  parameter int unsigned MAX_POINTS  = nns_pkg::DEF_MAX_POINTS,
  parameter int unsigned MAX_DIMS    = nns_pkg::DEF_MAX_DIMS,
  parameter int unsigned MAX_TARGETS = nns_pkg::DEF_MAX_TARGETS,
  localparam int unsigned PW = $clog2(MAX_POINTS),
  localparam int unsigned DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
  localparam int unsigned TW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [8:0]           cfg_data_i,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic [1:0]           func_i,
  input  logic [7:0]           point_index_i,
  input  logic [2:0]           element_index_i,
  input  logic [15:0]          element_value_i,
  output logic                 feat_we_o,
  output logic [PW+DW-1:0]     feat_waddr_o,
  output logic                 tgt_we_o,
  output logic [PW+TW-1:0]     tgt_waddr_o,
  output logic                 qry_we_o,
  output logic [DW-1:0]        qry_waddr_o,
  output logic [15:0]          wdata_o,
  output logic                 push_o,
  output nns_pkg::cmd_t        cmd_o
);

  logic       mode_q;
  logic [8:0] pcnt_q;
  logic [3:0] dcnt_q;
  logic [2:0] tcnt_q;

  logic        accept;
  logic        pt_ok;
  logic [31:0] pc_full;
  logic [31:0] dc_full;
  logic [31:0] tc_full;
  logic [31:0] tc_lim;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      pcnt_q <= 9'd1;
      dcnt_q <= 4'd1;
      tcnt_q <= 3'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nns_pkg::CFG_METRIC_MODE:  mode_q <= cfg_data_i[0];
        nns_pkg::CFG_POINT_COUNT:  pcnt_q <= cfg_data_i;
        nns_pkg::CFG_DIM_COUNT:    dcnt_q <= cfg_data_i[3:0];
        nns_pkg::CFG_TARGET_COUNT: tcnt_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // effective counts
  always_comb begin
    pc_full = nns_pkg::clamp_count(32'(pcnt_q), 32'(MAX_POINTS));
    dc_full = nns_pkg::clamp_count(32'(dcnt_q), 32'(MAX_DIMS));
    tc_full = nns_pkg::clamp_count(32'(tcnt_q), 32'(MAX_TARGETS));
    tc_lim  = (tc_full > 32'(nns_pkg::RESULT_LIMIT)) ? 32'(nns_pkg::RESULT_LIMIT) : tc_full;
    cmd_o.mode = mode_q;
    cmd_o.pc   = pc_full[8:0];
    cmd_o.dc   = dc_full[3:0];
    cmd_o.tc   = tc_lim[2:0];
  end

  assign accept = start_i & ~busy_i;
  assign pt_ok  = 32'(point_index_i) < 32'(MAX_POINTS);

  // store addresses
  assign feat_waddr_o = {PW'(point_index_i), DW'(element_index_i)};
  assign tgt_waddr_o  = {PW'(point_index_i), TW'(element_index_i)};
  assign qry_waddr_o  = DW'(element_index_i);
  assign wdata_o      = element_value_i;

  // classify the beat: store loads, or a query element that may start a search
  always_comb begin
    feat_we_o = 1'b0;
    tgt_we_o  = 1'b0;
    qry_we_o  = 1'b0;
    push_o    = 1'b0;
    unique case (func_i)
      nns_pkg::FUNC_FEATURE: begin
        feat_we_o = accept & pt_ok & (32'(element_index_i) < 32'(MAX_DIMS));
      end
      nns_pkg::FUNC_TARGET: begin
        tgt_we_o = accept & pt_ok & (32'(element_index_i) < 32'(MAX_TARGETS));
      end
      nns_pkg::FUNC_QUERY: begin
        qry_we_o = accept & (32'(element_index_i) < 32'(MAX_DIMS));
        push_o   = qry_we_o & (32'(element_index_i) == dc_full - 32'd1);
      end
      default: ;
    endcase
  end

endmodule

[design/nns_cmd_fifo.sv]
module nns_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  nns_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          empty_o,
  output nns_pkg::cmd_t cmd_o
);

  localparam int unsigned PTR_W = $clog2(nns_pkg::CMD_DEPTH);

  nns_pkg::cmd_t    mem_q [nns_pkg::CMD_DEPTH];
  logic [PTR_W-1:0] wptr_q;
  logic [PTR_W-1:0] rptr_q;
  logic [PTR_W:0]   cnt_q;
  logic             do_push;
  logic             do_pop;

  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & (32'(cnt_q) < 32'(nns_pkg::CMD_DEPTH));
  assign do_pop  = pop_i & ~empty_o;
  assign cmd_o   = mem_q[rptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

endmodule

[design/nns_back.sv]
module nns_back #(
  parameter int unsigned MAX_POINTS  = nns_pkg::DEF_MAX_POINTS,
  parameter int unsigned MAX_DIMS    = nns_pkg::DEF_MAX_DIMS,
  parameter int unsigned MAX_TARGETS = nns_pkg::DEF_MAX_TARGETS,
  localparam int unsigned PW = $clog2(MAX_POINTS),
  localparam int unsigned DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
  localparam int unsigned TW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_empty_i,
  input  nns_pkg::cmd_t              cmd_i,
  output logic                       cmd_pop_o,
  output logic                       busy_o,
  output logic [PW+DW-1:0]           feat_raddr_o,
  input  logic [15:0]                feat_rdata_i,
  output logic [DW-1:0]              qry_raddr_o,
  input  logic [15:0]                qry_rdata_i,
  output logic [PW+TW-1:0]           tgt_raddr_o,
  input  logic [15:0]                tgt_rdata_i,
  output logic                       result_valid_o,
  output logic [1:0]                 target_index_o,
  output logic signed [15:0]         target_value_o,
  output logic [7:0]                 nearest_point_o,
  output logic [nns_pkg::DIST_W-1:0] nearest_distance_o,
  output logic                       last_result_o
);

  localparam int unsigned ACC_W = 32 + DW;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  // per element tags travelling with the pipeline
  typedef struct packed {
    logic first_dim;
    logic last_dim;
    logic first_pt;
  } tag_t;

  state_e        state_q, state_d;
  nns_pkg::cmd_t cmd_q;
  logic [PW-1:0] p_q, p_d;
  logic [DW-1:0] d_q, d_d;
  logic [1:0]    k_q, k_d;

  logic issue;
  logic last_d;
  logic last_p;
  logic last_k;
  tag_t tag0;

  logic          v1_q, v2_q, v3_q, v4_q;
  tag_t          t1_q, t2_q, t3_q;
  logic [PW-1:0] p1_q, p2_q, p3_q, p4_q;

  logic signed [16:0] diff;
  logic [16:0]        neg;
  logic [15:0]        mag;
  logic [15:0]        mag2_q, mag3_q;
  logic [31:0]        sq;
  logic [31:0]        sq3_q;
  logic [ACC_W-1:0]   term;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [ACC_W-1:0]   dist4_q;
  logic               pz4_q;

  logic [PW-1:0]    best_p_q;
  logic [ACC_W-1:0] best_d_q;
  logic             take;

  logic          ev_q;
  logic [1:0]    ek_q;
  logic          elast_q;
  logic [PW+7:0] best_p_ext;
  logic [63:0]   best_d_ext;

  // scan position compares
  assign last_d = 32'(d_q) == 32'(cmd_q.dc) - 32'd1;
  assign last_p = 32'(p_q) == 32'(cmd_q.pc) - 32'd1;
  assign last_k = 32'(k_q) == 32'(cmd_q.tc) - 32'd1;

  // sequencer: scan all points and dimensions, drain, then read out targets
  always_comb begin
    state_d   = state_q;
    p_d       = p_q;
    d_d       = d_q;
    k_d       = k_q;
    issue     = 1'b0;
    cmd_pop_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          p_d       = '0;
          d_d       = '0;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        issue = 1'b1;
        if (last_d) begin
          d_d = '0;
          if (last_p) begin
            state_d = ST_DRAIN;
          end else begin
            p_d = p_q + 1'b1;
          end
        end else begin
          d_d = d_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        k_d = '0;
        if (!v1_q && !v2_q && !v3_q && !v4_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        k_d = k_q + 1'b1;
        if (last_k) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign feat_raddr_o = {p_q, d_q};
  assign qry_raddr_o  = d_q;
  assign tgt_raddr_o  = {best_p_q, TW'(k_q)};

  assign tag0.first_dim = (d_q == '0);
  assign tag0.last_dim  = last_d;
  assign tag0.first_pt  = (p_q == '0);

  // element difference magnitude
  always_comb begin
    diff = $signed({qry_rdata_i[15], qry_rdata_i}) - $signed({feat_rdata_i[15], feat_rdata_i});
    neg  = -diff;
    mag  = diff[16] ? neg[15:0] : diff[15:0];
  end

  // square of the registered magnitude
  assign sq = {16'b0, mag2_q} * {16'b0, mag2_q};

  // accumulate sum of squares or running maximum
  always_comb begin
    term = cmd_q.mode ? ACC_W'(mag3_q) : ACC_W'(sq3_q);
    if (t3_q.first_dim) begin
      acc_d = term;
    end else if (cmd_q.mode) begin
      acc_d = (term > acc_q) ? term : acc_q;
    end else begin
      acc_d = acc_q + term;
    end
  end

  // first point always taken, later ones only when strictly closer
  assign take = v4_q & (pz4_q | (dist4_q < best_d_q));

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      p_q     <= '0;
      d_q     <= '0;
      k_q     <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      ev_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      p_q     <= p_d;
      d_q     <= d_d;
      k_q     <= k_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q & t3_q.last_dim;
      ev_q    <= (state_q == ST_EMIT);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    t1_q   <= tag0;
    p1_q   <= p_q;
    t2_q   <= t1_q;
    p2_q   <= p1_q;
    mag2_q <= mag;
    t3_q   <= t2_q;
    p3_q   <= p2_q;
    mag3_q <= mag2_q;
    sq3_q  <= sq;
    if (v3_q) begin
      acc_q <= acc_d;
    end
    dist4_q <= acc_d;
    p4_q    <= p3_q;
    pz4_q   <= t3_q.first_pt;
    if (take) begin
      best_p_q <= p4_q;
      best_d_q <= dist4_q;
    end
    ek_q    <= k_q;
    elast_q <= last_k;
  end

  // result beat
  assign best_p_ext = {8'b0, best_p_q};
  assign best_d_ext = 64'(best_d_q);

  assign busy_o             = (state_q != ST_IDLE) | ev_q;
  assign result_valid_o     = ev_q;
  assign target_index_o     = ek_q;
  assign target_value_o     = tgt_rdata_i;
  assign last_result_o      = elast_q;
  assign nearest_point_o    = best_p_ext[7:0];
  assign nearest_distance_o = (best_d_ext > nns_pkg::DIST_MAX)
                              ? nns_pkg::DIST_MAX[nns_pkg::DIST_W-1:0]
                              : best_d_ext[nns_pkg::DIST_W-1:0];

endmodule

[design/nearest_neighbour_search_unit.sv]
// One-nearest-neighbour search over stored Q8.8 training points. Load
// beats (feature or target elements) and query elements other than the
// last are taken while busy_o is low. The query element at dimension
// count minus one starts a search: the feature store has a single read
// port, so once the request is picked up the scan reads one element per
// cycle over every point and dimension; after the pipeline drains, the
// target store is read once per target; the results follow one per
// cycle, each strobed by result_valid_o for exactly one cycle, and must
// be taken as they come.
// busy_o stays high from the search start until the last result beat.
// Stores have no defined contents after reset: load every entry a search
// will read first.
module nearest_neighbour_search_unit #(
  parameter int unsigned MAX_POINTS  = nns_pkg::DEF_MAX_POINTS,
  parameter int unsigned MAX_DIMS    = nns_pkg::DEF_MAX_DIMS,
  parameter int unsigned MAX_TARGETS = nns_pkg::DEF_MAX_TARGETS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [8:0]                 cfg_data_i,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [1:0]                 func_i,
  input  logic [7:0]                 point_index_i,
  input  logic [2:0]                 element_index_i,
  input  logic signed [15:0]         element_value_i,
  output logic                       result_valid_o,
  output logic [1:0]                 target_index_o,
  output logic signed [15:0]         target_value_o,
  output logic [7:0]                 nearest_point_o,
  output logic [nns_pkg::DIST_W-1:0] nearest_distance_o,
  output logic                       last_result_o
);

  localparam int unsigned PW = $clog2(MAX_POINTS);
  localparam int unsigned DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned TW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;

  logic               feat_we;
  logic [PW+DW-1:0]   feat_waddr;
  logic [PW+DW-1:0]   feat_raddr;
  logic [15:0]        feat_rdata;
  logic               tgt_we;
  logic [PW+TW-1:0]   tgt_waddr;
  logic [PW+TW-1:0]   tgt_raddr;
  logic [15:0]        tgt_rdata;
  logic               qry_we;
  logic [DW-1:0]      qry_waddr;
  logic [DW-1:0]      qry_raddr;
  logic [15:0]        qry_rdata;
  logic [15:0]        wdata;
  logic               push;
  nns_pkg::cmd_t      cmd_in;
  nns_pkg::cmd_t      cmd_head;
  logic               cmd_empty;
  logic               cmd_pop;
  logic               back_busy;

  assign busy_o = back_busy | ~cmd_empty;

  // front: configuration, load beats and search requests
  nns_front #(
    .MAX_POINTS  (MAX_POINTS),
    .MAX_DIMS    (MAX_DIMS),
    .MAX_TARGETS (MAX_TARGETS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .func_i          (func_i),
    .point_index_i   (point_index_i),
    .element_index_i (element_index_i),
    .element_value_i (element_value_i),
    .feat_we_o       (feat_we),
    .feat_waddr_o    (feat_waddr),
    .tgt_we_o        (tgt_we),
    .tgt_waddr_o     (tgt_waddr),
    .qry_we_o        (qry_we),
    .qry_waddr_o     (qry_waddr),
    .wdata_o         (wdata),
    .push_o          (push),
    .cmd_o           (cmd_in)
  );

  // search command queue
  nns_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .cmd_o   (cmd_head)
  );

  // stores
  nns_ram #(
    .WIDTH (16),
    .DEPTH (MAX_POINTS << DW)
  ) u_feat_ram (
    .clk_i   (clk_i),
    .we_i    (feat_we),
    .waddr_i (feat_waddr),
    .wdata_i (wdata),
    .raddr_i (feat_raddr),
    .rdata_o (feat_rdata)
  );

  nns_ram #(
    .WIDTH (16),
    .DEPTH (MAX_POINTS << TW)
  ) u_tgt_ram (
    .clk_i   (clk_i),
    .we_i    (tgt_we),
    .waddr_i (tgt_waddr),
    .wdata_i (wdata),
    .raddr_i (tgt_raddr),
    .rdata_o (tgt_rdata)
  );

  nns_ram #(
    .WIDTH (16),
    .DEPTH (1 << DW)
  ) u_qry_ram (
    .clk_i   (clk_i),
    .we_i    (qry_we),
    .waddr_i (qry_waddr),
    .wdata_i (wdata),
    .raddr_i (qry_raddr),
    .rdata_o (qry_rdata)
  );

  // back: distance scan and result read-out
  nns_back #(
    .MAX_POINTS  (MAX_POINTS),
    .MAX_DIMS    (MAX_DIMS),
    .MAX_TARGETS (MAX_TARGETS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_empty_i        (cmd_empty),
    .cmd_i              (cmd_head),
    .cmd_pop_o          (cmd_pop),
    .busy_o             (back_busy),
    .feat_raddr_o       (feat_raddr),
    .feat_rdata_i       (feat_rdata),
    .qry_raddr_o        (qry_raddr),
    .qry_rdata_i        (qry_rdata),
    .tgt_raddr_o        (tgt_raddr),
    .tgt_rdata_i        (tgt_rdata),
    .result_valid_o     (result_valid_o),
    .target_index_o     (target_index_o),
    .target_value_o     (target_value_o),
    .nearest_point_o    (nearest_point_o),
    .nearest_distance_o (nearest_distance_o),
    .last_result_o      (last_result_o)
  );

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;

  localparam int unsigned NP = nns_pkg::DEF_MAX_POINTS;
  localparam int unsigned ND = nns_pkg::DEF_MAX_DIMS;
  localparam int unsigned NT = nns_pkg::DEF_MAX_TARGETS;

  // points that the tests load and search
  localparam int unsigned WIN_PTS = 8;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic       METRIC_L2   = 1'b0;
  localparam logic       METRIC_LINF = 1'b1;

  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned IDLE_ITEMS   = 40;
  localparam int unsigned RANDOM_ITEMS = 70;

  typedef struct packed {
    logic [1:0]                 tidx;
    logic [15:0]                tval;
    logic [7:0]                 npt;
    logic [nns_pkg::DIST_W-1:0] ndist;
    logic                       last;
  } nn_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [1:0]                 cfg_idx_i;
  logic [8:0]                 cfg_data_i;
  logic                       start_i;
  logic                       busy_o;
  logic [1:0]                 func_i;
  logic [7:0]                 point_index_i;
  logic [2:0]                 element_index_i;
  logic signed [15:0]         element_value_i;
  logic                       result_valid_o;
  logic [1:0]                 target_index_o;
  logic signed [15:0]         target_value_o;
  logic [7:0]                 nearest_point_o;
  logic [nns_pkg::DIST_W-1:0] nearest_distance_o;
  logic                       last_result_o;

  // shadow of the stores and registers
  logic [15:0] feature_mem [NP*ND];
  logic [15:0] target_mem [NP*NT];
  logic [15:0] query_mem [ND];
  logic        metric_r;
  logic [8:0]  pt_cnt_r;
  logic [3:0]  dim_cnt_r;
  logic [2:0]  tgt_cnt_r;

  nn_result_t  nearest_due_q [$];
  nn_result_t  want;

  int unsigned fail_cnt;
  int unsigned results_seen;
  int unsigned searches;
  int unsigned eff_items;
  int unsigned cfg_writes;
  int unsigned quiet_cycles;
  int unsigned rand_base;
  bit          idle_en;

  nearest_neighbour_search_unit u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .func_i             (func_i),
    .point_index_i      (point_index_i),
    .element_index_i    (element_index_i),
    .element_value_i    (element_value_i),
    .result_valid_o     (result_valid_o),
    .target_index_o     (target_index_o),
    .target_value_o     (target_value_o),
    .nearest_point_o    (nearest_point_o),
    .nearest_distance_o (nearest_distance_o),
    .last_result_o      (last_result_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_cnt(int unsigned v, int unsigned hi);
    if (v < 1) begin
      return 1;
    end
    return (v > hi) ? hi : v;
  endfunction

  // squared euclidean or largest absolute difference to the query
  function automatic logic [63:0] query_distance(int unsigned p, int unsigned dims,
                                                 logic linf);
    logic [63:0] acc;
    logic [63:0] mag;
    longint      diff;
    acc = '0;
    for (int unsigned d = 0; d < dims; d++) begin
      diff = longint'($signed(query_mem[d])) - longint'($signed(feature_mem[p*ND+d]));
      mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
      if (linf) begin
        if (mag > acc) acc = mag;
      end else begin
        acc = acc + mag * mag;
      end
    end
    return acc;
  endfunction

  // update the shadow stores; a last query element queues the neighbour's targets
  function automatic void neighbour_predict(logic [1:0] f, logic [7:0] pt, logic [2:0] el,
                                            logic [15:0] val);
    int unsigned dc, pc, tc, best_p;
    logic [63:0] best_d, d;
    nn_result_t  r;
    case (f)
      nns_pkg::FUNC_FEATURE: begin
        if (pt < NP && el < ND) feature_mem[int'(pt)*ND+int'(el)] = val;
      end
      nns_pkg::FUNC_TARGET: begin
        if (pt < NP && el < NT) target_mem[int'(pt)*NT+int'(el)] = val;
      end
      nns_pkg::FUNC_QUERY: begin
        if (el < ND) begin
          query_mem[el] = val;
          dc = clamp_cnt(dim_cnt_r, ND);
          if (int'(el) == dc - 1) begin
            pc = clamp_cnt(pt_cnt_r, NP);
            tc = clamp_cnt(tgt_cnt_r, NT);
            if (tc > nns_pkg::RESULT_LIMIT) tc = nns_pkg::RESULT_LIMIT;
            best_p = 0;
            best_d = query_distance(0, dc, metric_r);
            for (int unsigned p = 1; p < pc; p++) begin
              d = query_distance(p, dc, metric_r);
              if (d < best_d) begin
                best_d = d;
                best_p = p;
              end
            end
            if (best_d > nns_pkg::DIST_MAX) best_d = nns_pkg::DIST_MAX;
            for (int unsigned k = 0; k < tc; k++) begin
              r.tidx  = 2'(k);
              r.tval  = target_mem[best_p*NT+k];
              r.npt   = 8'(best_p);
              r.ndist = best_d[nns_pkg::DIST_W-1:0];
              r.last  = (k == tc - 1);
              nearest_due_q = {nearest_due_q, r};
            end
            searches++;
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // q8.8 values leaning on the extremes
  function automatic logic [15:0] rand_q88();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'h8000;
      1: v = 16'h7FFF;
      2: v = 16'h0000;
      3: v = 16'hFFFF;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // send one command beat, with an occasional idle burst ahead of it
  task automatic send_beat(logic [1:0] f, logic [7:0] pt, logic [2:0] el, logic [15:0] val);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    start_i         <= 1'b1;
    func_i          <= f;
    point_index_i   <= pt;
    element_index_i <= el;
    element_value_i <= val;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    neighbour_predict(f, pt, el, val);
    eff_items++;
  endtask

  // hold off until every queued result has come and the block is quiet
  task automatic settle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (nearest_due_q.size() != 0 || busy_o !== 1'b0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      nns_pkg::CFG_METRIC_MODE:  metric_r  = data[0];
      nns_pkg::CFG_POINT_COUNT:  pt_cnt_r  = data;
      nns_pkg::CFG_DIM_COUNT:    dim_cnt_r = data[3:0];
      nns_pkg::CFG_TARGET_COUNT: tgt_cnt_r = data[2:0];
      default: begin
      end
    endcase
    cfg_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all_regs(logic [8:0] mode, logic [8:0] pc, logic [8:0] dc,
                                logic [8:0] tc);
    write_reg(nns_pkg::CFG_METRIC_MODE, mode);
    write_reg(nns_pkg::CFG_POINT_COUNT, pc);
    write_reg(nns_pkg::CFG_DIM_COUNT, dc);
    write_reg(nns_pkg::CFG_TARGET_COUNT, tc);
  endtask

  // fill every entry of the searched window so no search reads an unwritten one
  task automatic test_preload();
    for (int p = 0; p < WIN_PTS; p++) begin
      for (int d = 0; d < ND; d++) begin
        send_beat(nns_pkg::FUNC_FEATURE, 8'(p), 3'(d), (p < 2) ? 16'h7FFF : rand_q88());
      end
    end
    for (int p = 0; p < WIN_PTS; p++) begin
      for (int k = 0; k < NT; k++) begin
        send_beat(nns_pkg::FUNC_TARGET, 8'(p), 3'(k), rand_q88());
      end
    end
    for (int d = 0; d < ND; d++) begin
      send_beat(nns_pkg::FUNC_QUERY, 8'd0, 3'(d), 16'h8000);
    end
  endtask

  task automatic test_directed();
    // two equal points at the largest spread, the earlier one wins
    settle();
    write_all_regs(9'(METRIC_L2), 9'd2, 9'd8, 9'd4);
    send_beat(nns_pkg::FUNC_QUERY, 8'd0, 3'd7, 16'h8000);
    // same spread as largest absolute difference
    settle();
    write_reg(nns_pkg::CFG_METRIC_MODE, 9'(METRIC_LINF));
    send_beat(nns_pkg::FUNC_QUERY, 8'd0, 3'd7, 16'h8000);
    // exact match on the third point
    settle();
    write_reg(nns_pkg::CFG_POINT_COUNT, 9'd3);
    write_reg(nns_pkg::CFG_DIM_COUNT, 9'd1);
    send_beat(nns_pkg::FUNC_FEATURE, 8'd2, 3'd0, 16'h1234);
    send_beat(nns_pkg::FUNC_QUERY, 8'd0, 3'd0, 16'h1234);
    // ignored beats, a stored element that starts nothing, then a search
    send_beat(FUNC_UNUSED, 8'hFF, 3'd7, 16'hFFFF);
    send_beat(nns_pkg::FUNC_TARGET, 8'd2, 3'd6, 16'h5A5A);
    send_beat(nns_pkg::FUNC_QUERY, 8'd0, 3'd7, 16'h0F0F);
    send_beat(nns_pkg::FUNC_QUERY, 8'd0, 3'd0, 16'h1234);
    // zero counts act as one, mode takes bit 0 only
    settle();
    write_all_regs(9'h1FE, 9'd0, 9'd0, 9'd0);
    send_beat(nns_pkg::FUNC_QUERY, 8'hA5, 3'd0, 16'h0001);
    // dimension and target counts above the maximum saturate
    settle();
    write_all_regs(9'h1FF, 9'(WIN_PTS), 9'd15, 9'd7);
    send_beat(nns_pkg::FUNC_QUERY, 8'd0, 3'd7, 16'h7FFF);
    // scan of the whole loaded window with a fresh query
    settle();
    write_all_regs(9'(METRIC_L2), 9'(WIN_PTS), 9'(ND), 9'(NT));
    for (int e = 0; e < ND; e++) begin
      send_beat(nns_pkg::FUNC_QUERY, 8'(e), 3'(e), rand_q88());
    end
  endtask

  // mostly small point counts, now and then the whole window or zero
  task automatic random_config();
    logic [8:0] pc_data;
    case ($urandom_range(0, 9))
      7: pc_data = 9'(WIN_PTS);
      8: pc_data = 9'd0;
      default: pc_data = 9'($urandom_range(1, WIN_PTS));
    endcase
    write_all_regs(9'($urandom), pc_data, 9'($urandom), 9'($urandom));
  endtask

  task automatic random_beat();
    int unsigned r, dims, win;
    r    = $urandom_range(0, 99);
    dims = clamp_cnt(dim_cnt_r, ND);
    win  = clamp_cnt(pt_cnt_r, NP);
    if (r < 45) begin
      // whole query vector ending on the last dimension
      for (int unsigned e = 0; e < dims; e++) begin
        send_beat(nns_pkg::FUNC_QUERY, 8'($urandom), 3'(e), rand_q88());
      end
    end else if (r < 70) begin
      send_beat(nns_pkg::FUNC_FEATURE,
                $urandom_range(0, 1) ? 8'($urandom_range(0, win - 1)) : 8'($urandom),
                3'($urandom), rand_q88());
    end else if (r < 85) begin
      send_beat(nns_pkg::FUNC_TARGET, 8'($urandom), 3'($urandom), rand_q88());
    end else if (r < 92) begin
      send_beat(FUNC_UNUSED, 8'($urandom), 3'($urandom), 16'($urandom));
    end else begin
      // lone element, may or may not start a search
      send_beat(nns_pkg::FUNC_QUERY, 8'($urandom), 3'($urandom), rand_q88());
    end
  endtask

  task automatic run_phase();
    int unsigned base, n_items;
    bit          held;
    settle();
    random_config();
    base    = eff_items;
    n_items = $urandom_range(10, 20);
    held    = ($urandom_range(0, 2) != 0);
    while (eff_items - base < n_items) begin
      random_beat();
      if (!held && eff_items - base >= n_items / 2) begin
        settle();
        held = 1'b1;
      end
    end
  endtask

  task automatic test_random_idle();
    rand_base = eff_items;
    idle_en   = 1'b1;
    while (eff_items - rand_base < IDLE_ITEMS) run_phase();
  endtask

  // one configuration, then beats back to back with no idling
  task automatic test_random_streaming();
    idle_en = 1'b0;
    settle();
    random_config();
    while (eff_items - rand_base < RANDOM_ITEMS) random_beat();
  endtask

  // compare each result beat with the oldest queued neighbour
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      results_seen++;
      if (nearest_due_q.size() == 0) begin
        $error("unexpected result beat: target_index %0d nearest_point %0d",
               target_index_o, nearest_point_o);
        fail_cnt++;
      end else begin
        want = nearest_due_q.pop_front();
        if (target_index_o !== want.tidx) begin
          $error("target_index: expected %0d, got %0d", want.tidx, target_index_o);
          fail_cnt++;
        end
        if (target_value_o !== want.tval) begin
          $error("target_value: expected %0d, got %0d", $signed(want.tval), target_value_o);
          fail_cnt++;
        end
        if (nearest_point_o !== want.npt) begin
          $error("nearest_point: expected %0d, got %0d", want.npt, nearest_point_o);
          fail_cnt++;
        end
        if (nearest_distance_o !== want.ndist) begin
          $error("nearest_distance: expected %0d, got %0d", want.ndist, nearest_distance_o);
          fail_cnt++;
        end
        if (last_result_o !== want.last) begin
          $error("last_result: expected %0d, got %0d", want.last, last_result_o);
          fail_cnt++;
        end
      end
    end
  end

  // stall watchdog: no beat either way for too long
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (start_i && busy_o === 1'b0) || result_valid_o === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = nns_pkg::CFG_METRIC_MODE;
    cfg_data_i      = '0;
    start_i         = 1'b0;
    func_i          = nns_pkg::FUNC_FEATURE;
    point_index_i   = '0;
    element_index_i = '0;
    element_value_i = '0;
    metric_r        = METRIC_L2;
    pt_cnt_r        = 9'd1;
    dim_cnt_r       = 4'd1;
    tgt_cnt_r       = 3'd1;
    idle_en         = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_preload();
    test_directed();
    test_random_idle();
    test_random_streaming();
    settle();

    $display("searched %0d queries, checked %0d result beats", searches, results_seen);
    $display("sent %0d command beats across %0d register writes",
             eff_items, cfg_writes);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
